@@ hdl/sps_pkg.sv @@
// types, constants and phase helpers shared by the stepper phase sequencer
package sps_pkg;

  localparam int unsigned CFG_IDX_W    = 1;
  localparam int unsigned CFG_DATA_W   = 24;
  localparam int unsigned STEP_TOTAL_W = 16;
  localparam int unsigned PHASE_W      = 3;
  localparam int unsigned COIL_W       = 4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DELAY_CYCLES   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FULL_STEP_MODE = 1'b1;

  localparam logic [PHASE_W-1:0] PHASE_RESET   = 3'd1;
  localparam logic [PHASE_W-1:0] PHASE_LAST    = 3'd7;
  localparam logic [PHASE_W-1:0] PHASE_ODD_LOW = 3'd1;
  localparam logic [PHASE_W-1:0] FULL_STRIDE   = 3'd2;
  localparam logic [PHASE_W-1:0] HALF_STRIDE   = 3'd1;

  typedef enum logic [3:0] {
    MODE_IDLE  = 4'b0001,
    MODE_FWD   = 4'b0010,
    MODE_REW   = 4'b0100,
    MODE_DELAY = 4'b1000
  } mode_e;

  // coil levels per phase: bit0 = A, bit1 = B, bit2 = C, bit3 = D
  localparam logic [COIL_W-1:0] COIL_TABLE [8] = '{
    4'h1, 4'h3, 4'h2, 4'h6, 4'h4, 4'hC, 4'h8, 4'h9
  };

  typedef struct packed {
    logic                    step_request;
    logic                    rewind_request;
    logic                    stop_rewind;
    logic [STEP_TOTAL_W-1:0] step_total;
  } item_t;

  typedef struct packed {
    logic [COIL_W-1:0] coils;
    logic              ready_idle;
  } result_t;

  typedef struct packed {
    mode_e               mode;
    mode_e               ret_mode;
    logic [PHASE_W-1:0]  phase;
  } ctrl_t;

  function automatic logic [PHASE_W-1:0] next_phase(input logic [PHASE_W-1:0] p,
                                                    input logic               full,
                                                    input logic               backward);
    logic [PHASE_W-1:0] n;
    if (full) begin
      if (backward) begin
        n = (p == PHASE_ODD_LOW) ? PHASE_LAST : p - FULL_STRIDE;
      end else begin
        n = (p == PHASE_LAST) ? PHASE_ODD_LOW : p + FULL_STRIDE;
      end
    end else begin
      n = backward ? p - HALF_STRIDE : p + HALF_STRIDE;
    end
    return n;
  endfunction

endpackage

@@ hdl/sps_step.sv @@
// next-state and coil logic for one controller tick
module sps_step import sps_pkg::*; #(
  parameter int unsigned STEP_COUNT_WIDTH = 16,
  parameter int unsigned DELAY_WIDTH      = 24
) (
  input  item_t                       item_i,
  input  ctrl_t                       ctrl_i,
  input  logic [STEP_COUNT_WIDTH-1:0] steps_left_i,
  input  logic [DELAY_WIDTH-1:0]      delay_count_i,
  input  logic [DELAY_WIDTH-1:0]      delay_cycles_i,
  input  logic                        full_step_i,
  output ctrl_t                       ctrl_o,
  output logic [STEP_COUNT_WIDTH-1:0] steps_left_o,
  output logic [DELAY_WIDTH-1:0]      delay_count_o,
  output result_t                     result_o
);

  localparam int unsigned StepExtW =
    (STEP_COUNT_WIDTH > STEP_TOTAL_W) ? STEP_COUNT_WIDTH : STEP_TOTAL_W;

  logic [StepExtW-1:0]    total_ext;
  logic [DELAY_WIDTH-1:0] delay_inc;
  logic                   ready;

  assign total_ext = StepExtW'(item_i.step_total);
  assign delay_inc = delay_count_i + DELAY_WIDTH'(1);

  always_comb begin
    ctrl_o        = ctrl_i;
    steps_left_o  = steps_left_i;
    delay_count_o = delay_count_i;
    ready         = 1'b0;
    case (ctrl_i.mode)
      MODE_IDLE: begin
        // rewind wins over a step request
        if (item_i.rewind_request && !item_i.stop_rewind) begin
          ctrl_o.mode     = MODE_REW;
          ctrl_o.ret_mode = MODE_IDLE;
        end else if (item_i.step_request && (item_i.step_total != '0)) begin
          steps_left_o    = total_ext[STEP_COUNT_WIDTH-1:0];
          ctrl_o.mode     = MODE_FWD;
          ctrl_o.ret_mode = MODE_IDLE;
        end
        ready = 1'b1;
      end
      MODE_FWD: begin
        if (item_i.rewind_request) begin
          ctrl_o.mode  = MODE_REW;
          steps_left_o = '0;
        end else if (steps_left_i != '0) begin
          ctrl_o.phase = next_phase(ctrl_i.phase, full_step_i, 1'b0);
          ctrl_o.mode  = MODE_DELAY;
          steps_left_o = steps_left_i - STEP_COUNT_WIDTH'(1);
        end else begin
          ctrl_o.mode = MODE_IDLE;
        end
        ctrl_o.ret_mode = MODE_FWD;
      end
      MODE_REW: begin
        if (!item_i.stop_rewind) begin
          ctrl_o.phase = next_phase(ctrl_i.phase, full_step_i, 1'b1);
          ctrl_o.mode  = MODE_DELAY;
        end else begin
          ctrl_o.mode = MODE_IDLE;
        end
        ctrl_o.ret_mode = MODE_REW;
      end
      MODE_DELAY: begin
        delay_count_o = delay_inc;
        if (delay_inc == delay_cycles_i) begin
          delay_count_o   = '0;
          ctrl_o.mode     = (ctrl_i.ret_mode == MODE_REW) ? MODE_REW : MODE_FWD;
          ctrl_o.ret_mode = MODE_DELAY;
        end
      end
      default: begin
        ctrl_o.mode = MODE_IDLE;
      end
    endcase
  end

  assign result_o.coils      = COIL_TABLE[ctrl_o.phase];
  assign result_o.ready_idle = ready;

endmodule

@@ hdl/stepper_phase_sequencer_top.sv @@
// top level of the stepper phase sequencer: item register, controller state, result register
//
// Each input transfer is one controller tick. The block takes one item per cycle
// when the output is not stalled and gives one result per item: the item is held in
// the input register, then passes through the next-state and coil-table logic into
// the result register. The controller
// state (mode, phase, step and delay counters) updates when an item passes that
// logic, so back-to-back items are handled in order. A stall on the output
// backs up into in_stall_o once both registers are full.
module stepper_phase_sequencer_top import sps_pkg::*; #(
  parameter int unsigned STEP_COUNT_WIDTH = 16,
  parameter int unsigned DELAY_WIDTH      = 24
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic                    step_request_i,
  input  logic                    rewind_request_i,
  input  logic                    stop_rewind_i,
  input  logic [STEP_TOTAL_W-1:0] step_total_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic                    coil_a_o,
  output logic                    coil_b_o,
  output logic                    coil_c_o,
  output logic                    coil_d_o,
  output logic                    ready_idle_o,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int unsigned DelayExtW =
    (DELAY_WIDTH > CFG_DATA_W) ? DELAY_WIDTH : CFG_DATA_W;

  logic                        in_valid_q;
  item_t                       item_q;
  logic                        out_valid_q;
  result_t                     result_q;

  ctrl_t                       ctrl_q, ctrl_d;
  logic [STEP_COUNT_WIDTH-1:0] steps_left_q, steps_left_d;
  logic [DELAY_WIDTH-1:0]      delay_count_q, delay_count_d;
  result_t                     result_d;

  logic [DELAY_WIDTH-1:0]      delay_cycles_q;
  logic                        full_step_q;
  logic [DelayExtW-1:0]        cfg_ext;

  logic                        out_adv;
  logic                        proc_en;
  logic                        in_take;

  assign out_adv    = !out_valid_q || !out_stall_i;
  assign proc_en    = in_valid_q && out_adv;
  assign in_stall_o = in_valid_q && !out_adv;
  assign in_take    = in_valid_i && !in_stall_o;
  assign cfg_ext    = DelayExtW'(cfg_data_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_cycles_q <= DELAY_WIDTH'(1);
      full_step_q    <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_DELAY_CYCLES:   delay_cycles_q <= cfg_ext[DELAY_WIDTH-1:0];
        CFG_FULL_STEP_MODE: full_step_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (proc_en) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q.step_request   <= step_request_i;
      item_q.rewind_request <= rewind_request_i;
      item_q.stop_rewind    <= stop_rewind_i;
      item_q.step_total     <= step_total_i;
    end
  end

  sps_step #(
    .STEP_COUNT_WIDTH(STEP_COUNT_WIDTH),
    .DELAY_WIDTH     (DELAY_WIDTH)
  ) u_step (
    .item_i        (item_q),
    .ctrl_i        (ctrl_q),
    .steps_left_i  (steps_left_q),
    .delay_count_i (delay_count_q),
    .delay_cycles_i(delay_cycles_q),
    .full_step_i   (full_step_q),
    .ctrl_o        (ctrl_d),
    .steps_left_o  (steps_left_d),
    .delay_count_o (delay_count_d),
    .result_o      (result_d)
  );

  // controller state advances once per processed tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q.mode     <= MODE_IDLE;
      ctrl_q.ret_mode <= MODE_IDLE;
      ctrl_q.phase    <= PHASE_RESET;
      steps_left_q    <= '0;
      delay_count_q   <= '0;
    end else if (proc_en) begin
      ctrl_q        <= ctrl_d;
      steps_left_q  <= steps_left_d;
      delay_count_q <= delay_count_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (proc_en) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc_en) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign coil_a_o     = result_q.coils[0];
  assign coil_b_o     = result_q.coils[1];
  assign coil_c_o     = result_q.coils[2];
  assign coil_d_o     = result_q.coils[3];
  assign ready_idle_o = result_q.ready_idle;

`ifndef ASSERT_OFF
  a_idle_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc_en && (ctrl_q.mode == MODE_IDLE) |=> out_valid_o && ready_idle_o)
    else $error("idle tick did not report ready");

  a_busy_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc_en && (ctrl_q.mode != MODE_IDLE) |=> out_valid_o && !ready_idle_o)
    else $error("non-idle tick reported ready");

  a_rewind_abort: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc_en && (ctrl_q.mode == MODE_FWD) && item_q.rewind_request
    |=> (ctrl_q.mode == MODE_REW) && (steps_left_q == '0))
    else $error("rewind request did not abort forward run");

  a_phase_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !proc_en || (ctrl_q.mode == MODE_IDLE) || (ctrl_q.mode == MODE_DELAY)
    |=> ctrl_q.phase == $past(ctrl_q.phase))
    else $error("phase moved outside a step");
`endif

endmodule
